FILE: hdl/ikcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikcf_pkg: shared types and constants for the chain follow solver
// Word layouts, datapath op codes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package ikcf_pkg;

  localparam int unsigned SEGMENTS = 4;
  localparam int unsigned SegIdxW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  localparam int unsigned CoordW   = 20;
  localparam int unsigned DirW     = 16;
  localparam int unsigned LenW     = 16;
  localparam int unsigned DiffW    = 21;
  localparam int unsigned ProdW    = 2 * DiffW;
  localparam int unsigned OffW     = 18;
  localparam int unsigned RootW    = 29;
  localparam int unsigned SqSteps  = RootW;
  localparam int unsigned QuotW    = 17;
  localparam int unsigned DvdW     = 45;
  localparam int unsigned StepCntW = 5;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgSegLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBaseX  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBaseY  = 2'd2;

  localparam logic [LenW-1:0]    SegLenReset = 16'd640;
  localparam logic signed [DirW-1:0] OneQ14  = 16'sd16384;

  typedef logic [4:0] op_t;
  localparam op_t OpNone       = 5'd0;
  localparam op_t OpLoad       = 5'd1;
  localparam op_t OpDiff       = 5'd2;
  localparam op_t OpMulDxDx    = 5'd3;
  localparam op_t OpMulDyDy    = 5'd4;
  localparam op_t OpN2         = 5'd5;
  localparam op_t OpSqInit     = 5'd6;
  localparam op_t OpSqStep     = 5'd7;
  localparam op_t OpMulDxL     = 5'd8;
  localparam op_t OpMulDyL     = 5'd9;
  localparam op_t OpDivInit    = 5'd10;
  localparam op_t OpDivStep    = 5'd11;
  localparam op_t OpDivSave    = 5'd12;
  localparam op_t OpCommit     = 5'd13;
  localparam op_t OpMulLc      = 5'd14;
  localparam op_t OpMulLs      = 5'd15;
  localparam op_t OpOffX       = 5'd16;
  localparam op_t OpOffY       = 5'd17;
  localparam op_t OpCommitKeep = 5'd18;
  localparam op_t OpSetBase    = 5'd19;
  localparam op_t OpEnd        = 5'd20;
  localparam op_t OpWrOrg      = 5'd21;
  localparam op_t OpEmit       = 5'd22;

  typedef enum logic [1:0] {
    DivCos  = 2'd0,
    DivSin  = 2'd1,
    DivOffX = 2'd2,
    DivOffY = 2'd3
  } div_sel_e;

  typedef struct packed {
    op_t                op;
    logic [SegIdxW-1:0] idx;
    div_sel_e           dsel;
  } cmd_t;

  typedef struct packed {
    logic n2_zero;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
  } in_word_t;

  typedef struct packed {
    logic [3:0]               segment_index;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] stop_x;
    logic signed [CoordW-1:0] stop_y;
    logic                     last;
  } out_word_t;

endpackage

FILE: hdl/ikcf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikcf_dp: solver datapath
// Segment store, shared multiplier, serial square root, serial divider, output register.
// ----------------------------------------------------------------------------
module ikcf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ikcf_pkg::cmd_t                    cmd_i,
  output ikcf_pkg::status_t                 status_o,
  input  ikcf_pkg::in_word_t                in_data_i,
  input  logic                              cfg_we_i,
  input  logic [ikcf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ikcf_pkg::CoordW-1:0]       cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ikcf_pkg::out_word_t               out_data_o
);

  function automatic logic signed [ikcf_pkg::CoordW-1:0] sat20(
    input logic signed [ikcf_pkg::DiffW-1:0] v
  );
    logic signed [ikcf_pkg::CoordW-1:0] r;
    begin
      if (v[ikcf_pkg::DiffW-1] != v[ikcf_pkg::DiffW-2]) begin
        r = v[ikcf_pkg::DiffW-1] ? {1'b1, {(ikcf_pkg::CoordW-1){1'b0}}}
                                 : {1'b0, {(ikcf_pkg::CoordW-1){1'b1}}};
      end else begin
        r = v[ikcf_pkg::CoordW-1:0];
      end
      return r;
    end
  endfunction

  // configuration
  logic [ikcf_pkg::LenW-1:0]          seg_len_q;
  logic signed [ikcf_pkg::CoordW-1:0] base_x_q, base_y_q;

  // segment store
  logic signed [ikcf_pkg::CoordW-1:0] org_x_q [ikcf_pkg::SEGMENTS];
  logic signed [ikcf_pkg::CoordW-1:0] org_y_q [ikcf_pkg::SEGMENTS];
  logic signed [ikcf_pkg::DirW-1:0]   cos_q   [ikcf_pkg::SEGMENTS];
  logic signed [ikcf_pkg::DirW-1:0]   sin_q   [ikcf_pkg::SEGMENTS];

  // working registers
  logic signed [ikcf_pkg::CoordW-1:0] aim_x_q, aim_y_q, end_x_q, end_y_q;
  logic signed [ikcf_pkg::DiffW-1:0]  dx_q, dy_q;
  logic signed [ikcf_pkg::ProdW-1:0]  prod_q;
  logic [ikcf_pkg::ProdW-1:0]         n2_q;
  logic [ikcf_pkg::ProdW+15:0]        sq_v_q;
  logic [ikcf_pkg::RootW+1:0]         sq_rem_q;
  logic [ikcf_pkg::RootW-1:0]         root_q;
  logic [ikcf_pkg::RootW-1:0]         div_rem_q;
  logic [ikcf_pkg::QuotW-1:0]         dlow_q, quot_q;
  logic                               neg_q;
  logic signed [ikcf_pkg::DirW-1:0]   new_cos_q, new_sin_q;
  logic signed [ikcf_pkg::OffW-1:0]   off_x_q, off_y_q;
  logic                               out_valid_q;
  ikcf_pkg::out_word_t                out_q;

  // selected segment
  logic signed [ikcf_pkg::CoordW-1:0] rd_org_x, rd_org_y;
  logic signed [ikcf_pkg::DirW-1:0]   rd_cos, rd_sin;
  assign rd_org_x = org_x_q[cmd_i.idx];
  assign rd_org_y = org_y_q[cmd_i.idx];
  assign rd_cos   = cos_q[cmd_i.idx];
  assign rd_sin   = sin_q[cmd_i.idx];

  // shared multiplier
  logic signed [ikcf_pkg::DiffW-1:0] mul_a, mul_b, len_s;
  logic signed [ikcf_pkg::ProdW-1:0] mul_p;
  assign len_s = signed'({5'b0, seg_len_q});
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      ikcf_pkg::OpMulDxDx: begin mul_a = dx_q;  mul_b = dx_q; end
      ikcf_pkg::OpMulDyDy: begin mul_a = dy_q;  mul_b = dy_q; end
      ikcf_pkg::OpMulDxL:  begin mul_a = dx_q;  mul_b = len_s; end
      ikcf_pkg::OpMulDyL:  begin mul_a = dy_q;  mul_b = len_s; end
      ikcf_pkg::OpMulLc:   begin mul_a = len_s; mul_b = ikcf_pkg::DiffW'(rd_cos); end
      ikcf_pkg::OpMulLs:   begin mul_a = len_s; mul_b = ikcf_pkg::DiffW'(rd_sin); end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // magnitudes
  logic [ikcf_pkg::DiffW-1:0] dx_abs, dy_abs;
  logic [ikcf_pkg::ProdW-1:0] p_abs;
  assign dx_abs = dx_q[ikcf_pkg::DiffW-1] ? ikcf_pkg::DiffW'(-dx_q) : dx_q;
  assign dy_abs = dy_q[ikcf_pkg::DiffW-1] ? ikcf_pkg::DiffW'(-dy_q) : dy_q;
  assign p_abs  = prod_q[ikcf_pkg::ProdW-1] ? ikcf_pkg::ProdW'(-prod_q) : prod_q;

  // end offset: product / 16384, rounded half away from zero
  logic [ikcf_pkg::ProdW-1:0]       rnd_sum;
  logic signed [ikcf_pkg::OffW-1:0] rnd_mag, rnd_off;
  assign rnd_sum = p_abs + ikcf_pkg::ProdW'(8192);
  assign rnd_mag = signed'(rnd_sum[ikcf_pkg::OffW+13:14]);
  assign rnd_off = prod_q[ikcf_pkg::ProdW-1] ? -rnd_mag : rnd_mag;

  // square root step (two radicand bits per cycle)
  logic [ikcf_pkg::RootW+3:0] sq_r2, sq_t;
  assign sq_r2 = {sq_rem_q, sq_v_q[ikcf_pkg::ProdW+15:ikcf_pkg::ProdW+14]};
  assign sq_t  = {2'b00, root_q, 2'b01};

  // divider init and step
  logic [ikcf_pkg::DvdW+4:0] mag_w;
  logic [ikcf_pkg::DvdW-1:0] dvd;
  logic                      dvd_neg;
  always_comb begin
    mag_w   = '0;
    dvd_neg = 1'b0;
    case (cmd_i.dsel)
      ikcf_pkg::DivCos: begin
        mag_w = (ikcf_pkg::DvdW+5)'({dx_abs, 22'b0}); dvd_neg = dx_q[ikcf_pkg::DiffW-1];
      end
      ikcf_pkg::DivSin: begin
        mag_w = (ikcf_pkg::DvdW+5)'({dy_abs, 22'b0}); dvd_neg = dy_q[ikcf_pkg::DiffW-1];
      end
      default: begin
        mag_w = {p_abs, 8'b0}; dvd_neg = prod_q[ikcf_pkg::ProdW-1];
      end
    endcase
  end
  assign dvd = mag_w[ikcf_pkg::DvdW-1:0] + ikcf_pkg::DvdW'(root_q >> 1);

  logic [ikcf_pkg::RootW:0]         div_r2;
  logic                             div_ge;
  logic signed [ikcf_pkg::OffW-1:0] q_mag, q_s;
  assign div_r2 = {div_rem_q, dlow_q[ikcf_pkg::QuotW-1]};
  assign div_ge = div_r2 >= {1'b0, root_q};
  assign q_mag  = signed'({1'b0, quot_q});
  assign q_s    = neg_q ? -q_mag : q_mag;

  // placement and ends
  logic signed [ikcf_pkg::CoordW-1:0] nx, ny, ex, ey;
  assign nx = sat20(ikcf_pkg::DiffW'(aim_x_q) - ikcf_pkg::DiffW'(off_x_q));
  assign ny = sat20(ikcf_pkg::DiffW'(aim_y_q) - ikcf_pkg::DiffW'(off_y_q));
  assign ex = sat20(ikcf_pkg::DiffW'(rd_org_x) + ikcf_pkg::DiffW'(off_x_q));
  assign ey = sat20(ikcf_pkg::DiffW'(rd_org_y) + ikcf_pkg::DiffW'(off_y_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q <= ikcf_pkg::SegLenReset;
      base_x_q  <= '0;
      base_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ikcf_pkg::CfgSegLen: seg_len_q <= cfg_data_i[ikcf_pkg::LenW-1:0];
        ikcf_pkg::CfgBaseX:  base_x_q  <= signed'(cfg_data_i);
        ikcf_pkg::CfgBaseY:  base_y_q  <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ikcf_pkg::SEGMENTS; i++) begin
        org_x_q[i] <= '0;
        org_y_q[i] <= '0;
        cos_q[i]   <= ikcf_pkg::OneQ14;
        sin_q[i]   <= '0;
      end
    end else begin
      case (cmd_i.op)
        ikcf_pkg::OpCommit: begin
          org_x_q[cmd_i.idx] <= nx;
          org_y_q[cmd_i.idx] <= ny;
          cos_q[cmd_i.idx]   <= new_cos_q;
          sin_q[cmd_i.idx]   <= new_sin_q;
        end
        ikcf_pkg::OpCommitKeep: begin
          org_x_q[cmd_i.idx] <= nx;
          org_y_q[cmd_i.idx] <= ny;
        end
        ikcf_pkg::OpSetBase: begin
          org_x_q[ikcf_pkg::SEGMENTS-1] <= base_x_q;
          org_y_q[ikcf_pkg::SEGMENTS-1] <= base_y_q;
        end
        ikcf_pkg::OpWrOrg: begin
          org_x_q[cmd_i.idx] <= end_x_q;
          org_y_q[cmd_i.idx] <= end_y_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ikcf_pkg::OpLoad: begin
        aim_x_q <= in_data_i.target_x;
        aim_y_q <= in_data_i.target_y;
      end
      ikcf_pkg::OpDiff: begin
        dx_q <= ikcf_pkg::DiffW'(aim_x_q) - ikcf_pkg::DiffW'(rd_org_x);
        dy_q <= ikcf_pkg::DiffW'(aim_y_q) - ikcf_pkg::DiffW'(rd_org_y);
      end
      ikcf_pkg::OpMulDxDx, ikcf_pkg::OpMulDxL, ikcf_pkg::OpMulDyL,
      ikcf_pkg::OpMulLc, ikcf_pkg::OpMulLs: prod_q <= mul_p;
      ikcf_pkg::OpMulDyDy: begin
        n2_q   <= unsigned'(prod_q);
        prod_q <= mul_p;
      end
      ikcf_pkg::OpN2: n2_q <= n2_q + unsigned'(prod_q);
      ikcf_pkg::OpSqInit: begin
        sq_v_q   <= {n2_q, 16'b0};
        sq_rem_q <= '0;
        root_q   <= '0;
      end
      ikcf_pkg::OpSqStep: begin
        sq_v_q <= {sq_v_q[ikcf_pkg::ProdW+13:0], 2'b00};
        if (sq_r2 >= sq_t) begin
          sq_rem_q <= (ikcf_pkg::RootW+2)'(sq_r2 - sq_t);
          root_q   <= {root_q[ikcf_pkg::RootW-2:0], 1'b1};
        end else begin
          sq_rem_q <= sq_r2[ikcf_pkg::RootW+1:0];
          root_q   <= {root_q[ikcf_pkg::RootW-2:0], 1'b0};
        end
      end
      ikcf_pkg::OpDivInit: begin
        div_rem_q <= {1'b0, dvd[ikcf_pkg::DvdW-1:ikcf_pkg::QuotW]};
        dlow_q    <= dvd[ikcf_pkg::QuotW-1:0];
        quot_q    <= '0;
        neg_q     <= dvd_neg;
      end
      ikcf_pkg::OpDivStep: begin
        dlow_q <= {dlow_q[ikcf_pkg::QuotW-2:0], 1'b0};
        quot_q <= {quot_q[ikcf_pkg::QuotW-2:0], div_ge};
        div_rem_q <= div_ge ? ikcf_pkg::RootW'(div_r2 - {1'b0, root_q})
                            : div_r2[ikcf_pkg::RootW-1:0];
      end
      ikcf_pkg::OpDivSave: begin
        case (cmd_i.dsel)
          ikcf_pkg::DivCos:  new_cos_q <= q_s[ikcf_pkg::DirW-1:0];
          ikcf_pkg::DivSin:  new_sin_q <= q_s[ikcf_pkg::DirW-1:0];
          ikcf_pkg::DivOffX: off_x_q   <= q_s;
          default:           off_y_q   <= q_s;
        endcase
      end
      ikcf_pkg::OpOffX: off_x_q <= rnd_off;
      ikcf_pkg::OpOffY: off_y_q <= rnd_off;
      ikcf_pkg::OpCommit, ikcf_pkg::OpCommitKeep: begin
        aim_x_q <= nx;
        aim_y_q <= ny;
      end
      ikcf_pkg::OpEnd: begin
        end_x_q <= ex;
        end_y_q <= ey;
      end
      ikcf_pkg::OpEmit: begin
        out_q.segment_index <= 4'(cmd_i.idx);
        out_q.start_x       <= rd_org_x;
        out_q.start_y       <= rd_org_y;
        out_q.stop_x        <= end_x_q;
        out_q.stop_y        <= end_y_q;
        out_q.last          <= (cmd_i.idx == ikcf_pkg::SegIdxW'(ikcf_pkg::SEGMENTS - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == ikcf_pkg::OpEmit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.n2_zero  = (n2_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: hdl/ikcf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikcf_ctrl: solver sequencer
// Steps the datapath through forward pass, backward pass and result output.
// ----------------------------------------------------------------------------
module ikcf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ikcf_pkg::status_t status_i,
  output ikcf_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StFDiff = 5'd1;
  localparam logic [4:0] StFSqx  = 5'd2;
  localparam logic [4:0] StFSqy  = 5'd3;
  localparam logic [4:0] StFN2   = 5'd4;
  localparam logic [4:0] StFChk  = 5'd5;
  localparam logic [4:0] StFSq   = 5'd6;
  localparam logic [4:0] StFMl   = 5'd7;
  localparam logic [4:0] StFDi   = 5'd8;
  localparam logic [4:0] StFDs   = 5'd9;
  localparam logic [4:0] StFDw   = 5'd10;
  localparam logic [4:0] StFCm   = 5'd11;
  localparam logic [4:0] StZMc   = 5'd12;
  localparam logic [4:0] StZOx   = 5'd13;
  localparam logic [4:0] StZMs   = 5'd14;
  localparam logic [4:0] StZOy   = 5'd15;
  localparam logic [4:0] StZCm   = 5'd16;
  localparam logic [4:0] StBBase = 5'd17;
  localparam logic [4:0] StEMc   = 5'd18;
  localparam logic [4:0] StEOx   = 5'd19;
  localparam logic [4:0] StEMs   = 5'd20;
  localparam logic [4:0] StEOy   = 5'd21;
  localparam logic [4:0] StEEnd  = 5'd22;
  localparam logic [4:0] StBWr   = 5'd23;
  localparam logic [4:0] StOEm   = 5'd24;

  localparam logic [ikcf_pkg::SegIdxW-1:0] LastIdx =
    ikcf_pkg::SegIdxW'(ikcf_pkg::SEGMENTS - 1);

  logic [4:0]                       state_q, state_d;
  logic [ikcf_pkg::SegIdxW-1:0]     idx_q, idx_d;
  logic [ikcf_pkg::StepCntW-1:0]    cnt_q, cnt_d;
  ikcf_pkg::div_sel_e               dph_q, dph_d;
  logic                             bwd_q, bwd_d;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    dph_d      = dph_q;
    bwd_d      = bwd_q;
    in_ready_o = 1'b0;
    cmd_o.op   = ikcf_pkg::OpNone;
    cmd_o.idx  = idx_q;
    cmd_o.dsel = dph_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ikcf_pkg::OpLoad;
          idx_d    = '0;
          state_d  = StFDiff;
        end
      end
      StFDiff: begin cmd_o.op = ikcf_pkg::OpDiff;    state_d = StFSqx; end
      StFSqx:  begin cmd_o.op = ikcf_pkg::OpMulDxDx; state_d = StFSqy; end
      StFSqy:  begin cmd_o.op = ikcf_pkg::OpMulDyDy; state_d = StFN2;  end
      StFN2:   begin cmd_o.op = ikcf_pkg::OpN2;      state_d = StFChk; end
      StFChk: begin
        if (status_i.n2_zero) begin
          state_d = StZMc;
        end else begin
          cmd_o.op = ikcf_pkg::OpSqInit;
          cnt_d    = '0;
          state_d  = StFSq;
        end
      end
      StFSq: begin
        cmd_o.op = ikcf_pkg::OpSqStep;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ikcf_pkg::StepCntW'(ikcf_pkg::SqSteps - 1)) begin
          dph_d   = ikcf_pkg::DivCos;
          state_d = StFDi;
        end
      end
      StFMl: begin
        cmd_o.op = (dph_q == ikcf_pkg::DivOffX) ? ikcf_pkg::OpMulDxL : ikcf_pkg::OpMulDyL;
        state_d  = StFDi;
      end
      StFDi: begin
        cmd_o.op = ikcf_pkg::OpDivInit;
        cnt_d    = '0;
        state_d  = StFDs;
      end
      StFDs: begin
        cmd_o.op = ikcf_pkg::OpDivStep;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ikcf_pkg::StepCntW'(ikcf_pkg::QuotW - 1)) state_d = StFDw;
      end
      StFDw: begin
        cmd_o.op = ikcf_pkg::OpDivSave;
        case (dph_q)
          ikcf_pkg::DivCos:  begin dph_d = ikcf_pkg::DivSin;  state_d = StFDi; end
          ikcf_pkg::DivSin:  begin dph_d = ikcf_pkg::DivOffX; state_d = StFMl; end
          ikcf_pkg::DivOffX: begin dph_d = ikcf_pkg::DivOffY; state_d = StFMl; end
          default:           state_d = StFCm;
        endcase
      end
      StFCm, StZCm: begin
        cmd_o.op = (state_q == StFCm) ? ikcf_pkg::OpCommit : ikcf_pkg::OpCommitKeep;
        if (idx_q == LastIdx) begin
          state_d = StBBase;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StFDiff;
        end
      end
      StZMc: begin cmd_o.op = ikcf_pkg::OpMulLc; state_d = StZOx; end
      StZOx: begin cmd_o.op = ikcf_pkg::OpOffX;  state_d = StZMs; end
      StZMs: begin cmd_o.op = ikcf_pkg::OpMulLs; state_d = StZOy; end
      StZOy: begin cmd_o.op = ikcf_pkg::OpOffY;  state_d = StZCm; end
      StBBase: begin
        cmd_o.op = ikcf_pkg::OpSetBase;
        idx_d    = LastIdx;
        bwd_d    = (ikcf_pkg::SEGMENTS > 1);
        state_d  = StEMc;
      end
      StEMc: begin cmd_o.op = ikcf_pkg::OpMulLc; state_d = StEOx; end
      StEOx: begin cmd_o.op = ikcf_pkg::OpOffX;  state_d = StEMs; end
      StEMs: begin cmd_o.op = ikcf_pkg::OpMulLs; state_d = StEOy; end
      StEOy: begin cmd_o.op = ikcf_pkg::OpOffY;  state_d = StEEnd; end
      StEEnd: begin
        cmd_o.op = ikcf_pkg::OpEnd;
        if (bwd_q) begin
          idx_d   = idx_q - 1'b1;
          state_d = StBWr;
        end else begin
          state_d = StOEm;
        end
      end
      StBWr: begin
        cmd_o.op = ikcf_pkg::OpWrOrg;
        bwd_d    = (idx_q != '0);
        state_d  = StEMc;
      end
      StOEm: begin
        if (status_i.out_free) begin
          cmd_o.op = ikcf_pkg::OpEmit;
          if (idx_q == LastIdx) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StEMc;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      cnt_q   <= '0;
      dph_q   <= ikcf_pkg::DivCos;
      bwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      dph_q   <= dph_d;
      bwd_q   <= bwd_d;
    end
  end

endmodule

FILE: hdl/ik_chain_follow_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_chain_follow_solver: 2-D follow-the-target IK for a chain of equal segments
// Sequencer plus datapath; one target word in, one result word per segment out.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel : in_valid_i/in_ready_o, word = target point (Q16.4).
//   out channel : out_valid_o/out_ready_i, SEGMENTS words per target, tip first,
//                 last set on the base segment's word.
//   cfg channel : cfg_valid_i/cfg_ready_o, always ready; index 0 segment length,
//                 1 base x, 2 base y. Write only while the solver is idle.
//   Timing: one target at a time. Each forward step runs a serial square root
//   and four divisions through one serial divider, or neither when the
//   direction vector is zero. Backward pass and output then run segment by
//   segment. The divisions take the largest share of each full forward step.
//   Stall: the output register holds a finished word; the sequencer waits on
//   it before loading the next, and in_ready_o only rises after the last word
//   has been loaded. Reset: length 640, base at the origin, all segments at
//   the origin pointing along +x; no clearing pass.
// ----------------------------------------------------------------------------
module ik_chain_follow_solver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ikcf_pkg::in_word_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ikcf_pkg::out_word_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ikcf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ikcf_pkg::CoordW-1:0]  cfg_data_i
);

  ikcf_pkg::cmd_t    cmd;
  ikcf_pkg::status_t status;

  // config registers take a write every cycle
  assign cfg_ready_o = 1'b1;

  ikcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ikcf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/ikcf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikcf_chk: port-level checks for the chain follow solver
// Watches the in/out channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module ikcf_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ikcf_pkg::out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second target taken while solving");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.segment_index <= 4'(ikcf_pkg::SEGMENTS - 1))
    else $error("segment index out of range");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=> !out_valid_o)
    else $error("word follows the last word of a target");

endmodule

bind ik_chain_follow_solver ikcf_chk u_ikcf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
